[design/assert_macros.svh]
// Assertion macros shared by the noise channel RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/ncle_pkg.sv]
// Constants, command codes and register indexes for the noise channel.
// No dependencies.
package ncle_pkg;

    localparam int CMD_W   = 3;
    localparam int LFSR_W  = 15;
    localparam int LEN_W   = 7;
    localparam int VOL_W   = 4;
    localparam int TIMER_W = 4;
    localparam int RELOAD_W = 22;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 4;

    localparam logic [CMD_W-1:0] CMD_TRIGGER   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LEN_CLK   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ENV_CLK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LFSR_STEP = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LEN_LOAD  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_START_VOLUME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_INCREASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_PERIOD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR_CODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_SHIFT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MODE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_ON    = 3'd6;

    localparam logic [LFSR_W-1:0]  LFSR_ALL_ONES = 15'h7FFF;
    localparam logic [LEN_W-1:0]   LENGTH_FULL   = 7'd64;
    localparam logic [VOL_W-1:0]   VOLUME_MAX    = 4'd15;
    localparam logic [TIMER_W-1:0] ENV_PERIOD_ZERO_TICKS = 4'd8;
    localparam logic [TIMER_W-1:0] ENV_TIMER_MAX = 4'd9;

    // Noise divisor table
    function automatic logic [6:0] divisor_lookup(input logic [2:0] code);
        logic [6:0] d;
        unique case (code)
            3'd0: d = 7'd8;
            3'd1: d = 7'd16;
            3'd2: d = 7'd32;
            3'd3: d = 7'd48;
            3'd4: d = 7'd64;
            3'd5: d = 7'd80;
            3'd6: d = 7'd96;
            default: d = 7'd112;
        endcase
        return d;
    endfunction

endpackage

[design/noise_channel_lfsr_envelope.sv]
// Noise channel top level: command register, state update and result register.
// Depends on ncle_pkg and assert_macros.svh.
//
// Usage:
//  - Input channel (in_valid/in_stall) carries one command word per cycle while
//    in_stall is low: trigger, length/envelope clock, LFSR step, length load.
//  - Output channel (out_valid/out_stall) returns one result word per command:
//    sample, channel_on and, on a trigger, timer_reload (zero otherwise).
//  - Config port (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the seven
//    channel registers; cfg_ready is always high. Write only while idle.
//  - The command word is held in the command register, then the state update
//    loads the result register, which drives out_valid and the result word.
//  - Throughput is one command per cycle while out_stall holds no result; the
//    channel state registers are updated in the same cycle the result register
//    loads, so back-to-back commands see each other's effects.
//  - When out_stall holds a result, the command register still takes one more
//    word; in_stall rises only once both stages are full.
//  - Reset clears all channel state, config registers and valid flags.

`include "assert_macros.svh"

module noise_channel_lfsr_envelope
    import ncle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CMD_W-1:0]      cmd,
    input  logic                  next_skips_length,
    input  logic                  next_clocks_envelope,
    input  logic [LEN_W-1:0]      length_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [VOL_W-1:0]      sample,
    output logic                  channel_on,
    output logic [RELOAD_W-1:0]   timer_reload,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [3:0] start_volume_reg;
    logic       env_increase_reg;
    logic [2:0] env_period_reg;
    logic [2:0] divisor_code_reg;
    logic [3:0] clock_shift_reg;
    logic       short_mode_reg;
    logic       length_on_reg;

    // command register
    logic             s1_valid_reg, s1_valid_next;
    logic [CMD_W-1:0] s1_cmd_reg;
    logic             s1_skips_reg;
    logic             s1_clocks_env_reg;
    logic [LEN_W-1:0] s1_len_reg;

    // channel state
    logic [LFSR_W-1:0]  noise_shift_reg, noise_shift_next;
    logic               enabled_reg, enabled_next;
    logic [LEN_W-1:0]   length_left_reg, length_left_next;
    logic [VOL_W-1:0]   volume_reg, volume_next;
    logic [TIMER_W-1:0] env_timer_reg, env_timer_next;
    logic               env_stopped_reg, env_stopped_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic [VOL_W-1:0]    sample_reg, sample_next;
    logic                channel_on_reg;
    logic [RELOAD_W-1:0] reload_reg, reload_next;

    logic               in_fire;
    logic               s1_adv;
    logic               s1_fire;
    logic [TIMER_W-1:0] period_ticks;
    logic               fb;
    logic [LFSR_W-1:0]  shifted;

    assign cfg_ready = 1'b1;

    assign s1_adv   = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_volume_reg <= '0;
            env_increase_reg <= 1'b0;
            env_period_reg   <= '0;
            divisor_code_reg <= '0;
            clock_shift_reg  <= '0;
            short_mode_reg   <= 1'b0;
            length_on_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START_VOLUME: start_volume_reg <= cfg_data;
                REG_ENV_INCREASE: env_increase_reg <= cfg_data[0];
                REG_ENV_PERIOD:   env_period_reg   <= cfg_data[2:0];
                REG_DIVISOR_CODE: divisor_code_reg <= cfg_data[2:0];
                REG_CLOCK_SHIFT:  clock_shift_reg  <= cfg_data;
                REG_SHORT_MODE:   short_mode_reg   <= cfg_data[0];
                REG_LENGTH_ON:    length_on_reg    <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg        <= cmd;
            s1_skips_reg      <= next_skips_length;
            s1_clocks_env_reg <= next_clocks_envelope;
            s1_len_reg        <= length_value;
        end
    end

    assign period_ticks = (env_period_reg == 3'd0) ? ENV_PERIOD_ZERO_TICKS
                                                   : {1'b0, env_period_reg};
    assign fb      = noise_shift_reg[0] ^ noise_shift_reg[1];
    assign shifted = {fb, noise_shift_reg[LFSR_W-1:1]};

    always_comb
    begin
        noise_shift_next = noise_shift_reg;
        enabled_next     = enabled_reg;
        length_left_next = length_left_reg;
        volume_next      = volume_reg;
        env_timer_next   = env_timer_reg;
        env_stopped_next = env_stopped_reg;
        reload_next      = '0;

        unique case (s1_cmd_reg)
            CMD_TRIGGER:
            begin
                enabled_next = !(start_volume_reg == 4'd0 && !env_increase_reg);
                if (length_left_reg == '0)
                    length_left_next = (length_on_reg && s1_skips_reg)
                                     ? LENGTH_FULL - 7'd1 : LENGTH_FULL;
                env_stopped_next = 1'b0;
                env_timer_next   = period_ticks + {3'd0, s1_clocks_env_reg};
                volume_next      = start_volume_reg;
                noise_shift_next = LFSR_ALL_ONES;
                reload_next      = {15'd0, divisor_lookup(divisor_code_reg)}
                                   << clock_shift_reg;
            end
            CMD_LEN_CLK:
            begin
                if (length_on_reg && length_left_reg != '0)
                begin
                    length_left_next = length_left_reg - 7'd1;
                    if (length_left_reg == 7'd1)
                        enabled_next = 1'b0;
                end
            end
            CMD_ENV_CLK:
            begin
                if (!env_stopped_reg)
                begin
                    if (env_timer_reg <= 4'd1)
                    begin
                        env_timer_next = period_ticks;
                        if (env_period_reg != 3'd0)
                        begin
                            if (env_increase_reg)
                            begin
                                if (volume_reg < VOLUME_MAX)
                                    volume_next = volume_reg + 4'd1;
                                else
                                    env_stopped_next = 1'b1;
                            end
                            else
                            begin
                                if (volume_reg != '0)
                                    volume_next = volume_reg - 4'd1;
                                else
                                    env_stopped_next = 1'b1;
                            end
                        end
                    end
                    else
                        env_timer_next = env_timer_reg - 4'd1;
                end
            end
            CMD_LFSR_STEP:
            begin
                noise_shift_next = shifted;
                if (short_mode_reg)
                    noise_shift_next[6] = fb;
            end
            CMD_LEN_LOAD:
            begin
                length_left_next = (s1_len_reg > LENGTH_FULL) ? LENGTH_FULL : s1_len_reg;
            end
            default: ;
        endcase

        sample_next = (!noise_shift_next[0] && enabled_next) ? volume_next : '0;
    end

    always_comb
    begin
        if (s1_adv)
            out_valid_next = s1_valid_reg;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_shift_reg <= '0;
            enabled_reg     <= 1'b0;
            length_left_reg <= '0;
            volume_reg      <= '0;
            env_timer_reg   <= '0;
            env_stopped_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                noise_shift_reg <= noise_shift_next;
                enabled_reg     <= enabled_next;
                length_left_reg <= length_left_next;
                volume_reg      <= volume_next;
                env_timer_reg   <= env_timer_next;
                env_stopped_reg <= env_stopped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            sample_reg     <= sample_next;
            channel_on_reg <= enabled_next;
            reload_reg     <= reload_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample       = sample_reg;
    assign channel_on   = channel_on_reg;
    assign timer_reload = reload_reg;

    `ASSERT_IMPLIES(a_sample_needs_on, clk, rst_n,
        out_valid_reg && sample_reg != '0, channel_on_reg)
    `ASSERT_IMPLIES(a_length_in_range, clk, rst_n, 1'b1, length_left_reg <= LENGTH_FULL)
    `ASSERT_IMPLIES(a_env_timer_range, clk, rst_n, 1'b1, env_timer_reg <= ENV_TIMER_MAX)
    `ASSERT_NEXT(a_trigger_seeds_lfsr, clk, rst_n,
        s1_fire && s1_cmd_reg == CMD_TRIGGER, noise_shift_reg == LFSR_ALL_ONES)

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the noise channel: a short directed table, then
// constrained-random command traffic checked against an in-bench channel model.
// Depends on ncle_pkg and noise_channel_lfsr_envelope.
module tb;
    import ncle_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_ITEMS  = 650;
    localparam int RECONFIG_GAP = 130;
    localparam int HOLD_CYCLES  = 60;
    localparam int MAX_REPORTS  = 10;

    // codes 5..7 are undefined and must leave the channel untouched
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    localparam logic [RELOAD_W-1:0] NOISE_DIV [8] = '{
        22'd8, 22'd16, 22'd32, 22'd48, 22'd64, 22'd80, 22'd96, 22'd112
    };

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             skip_len;
        logic             clk_env;
        logic [LEN_W-1:0] len;
    } cmd_word_t;

    typedef struct packed {
        logic [VOL_W-1:0]    sample;
        logic                on;
        logic [RELOAD_W-1:0] reload;
    } chan_out_t;

    typedef enum logic [1:0] {ROW_CMD, ROW_CHECK, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        cmd_word_t              word;
        chan_out_t              out;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [CMD_W-1:0]      cmd = CMD_TRIGGER;
    logic                  next_skips_length = 1'b0;
    logic                  next_clocks_envelope = 1'b0;
    logic [LEN_W-1:0]      length_value = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [VOL_W-1:0]      sample;
    logic                  channel_on;
    logic [RELOAD_W-1:0]   timer_reload;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_START_VOLUME;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    noise_channel_lfsr_envelope dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .cmd                  (cmd),
        .next_skips_length    (next_skips_length),
        .next_clocks_envelope (next_clocks_envelope),
        .length_value         (length_value),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .sample               (sample),
        .channel_on           (channel_on),
        .timer_reload         (timer_reload),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    always #5 clk = ~clk;

    // channel model state and register copy
    logic [LFSR_W-1:0]  lfsr_q;
    logic               ch_enabled;
    logic [LEN_W-1:0]   len_left;
    logic [VOL_W-1:0]   vol_q;
    logic [TIMER_W-1:0] env_tmr;
    logic               env_stop;
    logic [VOL_W-1:0]   r_start_vol;
    logic               r_env_inc;
    logic [2:0]         r_env_period;
    logic [2:0]         r_div_code;
    logic [3:0]         r_clk_shift;
    logic               r_short;
    logic               r_len_on;

    chan_out_t   expected_out_q[$];
    dir_row_t    dir_rows[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_served = 0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    int unsigned backpressure_cycles = 0;
    int unsigned err_count = 0;
    int unsigned n_cmds = 0;
    int unsigned n_triggers = 0;
    int unsigned n_results = 0;
    int unsigned n_cfg_writes = 0;

    task automatic channel_step(input cmd_word_t w, output chan_out_t r);
        logic [TIMER_W-1:0] ticks;
        logic               fb;
        r = '0;
        ticks = (r_env_period == 3'd0) ? ENV_PERIOD_ZERO_TICKS : TIMER_W'(r_env_period);
        case (w.op)
            CMD_TRIGGER:
            begin
                ch_enabled = 1'b1;
                if (len_left == '0)
                begin
                    len_left = LENGTH_FULL;
                    if (r_len_on && w.skip_len)
                        len_left = len_left - 1'b1;
                end
                env_stop = 1'b0;
                env_tmr = ticks + TIMER_W'(w.clk_env);
                vol_q = r_start_vol;
                lfsr_q = LFSR_ALL_ONES;
                r.reload = NOISE_DIV[r_div_code] << r_clk_shift;
                // DAC off: start volume zero while decreasing
                if (r_start_vol == '0 && !r_env_inc)
                    ch_enabled = 1'b0;
            end
            CMD_LEN_CLK:
            begin
                if (r_len_on && len_left != '0)
                begin
                    len_left = len_left - 1'b1;
                    if (len_left == '0)
                        ch_enabled = 1'b0;
                end
            end
            CMD_ENV_CLK:
            begin
                if (!env_stop)
                begin
                    if (env_tmr <= 1)
                    begin
                        env_tmr = ticks;
                        if (r_env_period != 3'd0)
                        begin
                            if (r_env_inc)
                            begin
                                if (vol_q < VOLUME_MAX)
                                    vol_q = vol_q + 1'b1;
                                else
                                    env_stop = 1'b1;
                            end
                            else
                            begin
                                if (vol_q != '0)
                                    vol_q = vol_q - 1'b1;
                                else
                                    env_stop = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        env_tmr = env_tmr - 1'b1;
                    end
                end
            end
            CMD_LFSR_STEP:
            begin
                fb = lfsr_q[0] ^ lfsr_q[1];
                lfsr_q = {fb, lfsr_q[LFSR_W-1:1]};
                if (r_short)
                    lfsr_q[6] = fb;
            end
            CMD_LEN_LOAD:
            begin
                len_left = (w.len > LENGTH_FULL) ? LENGTH_FULL : w.len;
            end
            default:
            begin
            end
        endcase
        r.sample = (!lfsr_q[0] && ch_enabled) ? vol_q : '0;
        r.on = ch_enabled;
    endtask

    task automatic send_cmd(input cmd_word_t w, input bit use_typed, input chan_out_t typed);
        chan_out_t pred;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        cmd = w.op;
        next_skips_length = w.skip_len;
        next_clocks_envelope = w.clk_env;
        length_value = w.len;
        do
            @(posedge clk);
        while (in_stall);
        channel_step(w, pred);
        expected_out_q.push_back(use_typed ? typed : pred);
        n_cmds++;
        if (w.op == CMD_TRIGGER)
            n_triggers++;
    endtask

    // drop valid and let every outstanding word drain before touching registers
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_out_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_START_VOLUME: r_start_vol = val;
            REG_ENV_INCREASE: r_env_inc = val[0];
            REG_ENV_PERIOD:   r_env_period = val[2:0];
            REG_DIVISOR_CODE: r_div_code = val[2:0];
            REG_CLOCK_SHIFT:  r_clk_shift = val;
            REG_SHORT_MODE:   r_short = val[0];
            REG_LENGTH_ON:    r_len_on = val[0];
            default: ;
        endcase
        n_cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_config();
        int unsigned mode;
        logic [CFG_DATA_W-1:0] val;
        mode = $urandom_range(0, 5);
        for (int i = REG_START_VOLUME; i <= REG_LENGTH_ON; i++)
        begin
            if (mode == 0)
                val = '0;
            else if (mode == 1)
                val = '1;
            else
                val = CFG_DATA_W'($urandom);
            // keep the DAC mostly powered so samples carry volume
            if (i == REG_START_VOLUME && mode > 2 && val == '0)
                val = CFG_DATA_W'($urandom_range(1, 15));
            cfg_write(CFG_IDX_W'(i), val);
        end
    endtask

    function automatic cmd_word_t random_cmd();
        cmd_word_t   w;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            w.op = CMD_TRIGGER;
        else if (pick < 30)
            w.op = CMD_LEN_CLK;
        else if (pick < 55)
            w.op = CMD_ENV_CLK;
        else if (pick < 83)
            w.op = CMD_LFSR_STEP;
        else if (pick < 95)
            w.op = CMD_LEN_LOAD;
        else
            w.op = CMD_W'($urandom_range(CMD_LEN_LOAD + 1, CMD_UNUSED));
        w.skip_len = 1'($urandom);
        w.clk_env = 1'($urandom);
        if ($urandom_range(0, 99) < 85)
            w.len = LEN_W'($urandom_range(0, LENGTH_FULL));
        else
            w.len = LEN_W'($urandom);
        return w;
    endfunction

    function automatic void row_cmd(logic [CMD_W-1:0] op, logic skip, logic envc,
                                    logic [LEN_W-1:0] len);
        dir_row_t r;
        r.kind = ROW_CMD;
        r.word = '{op: op, skip_len: skip, clk_env: envc, len: len};
        r.out = '0;
        r.reg_idx = '0;
        r.reg_val = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_chk(logic [CMD_W-1:0] op, logic [LEN_W-1:0] len,
                                    logic [VOL_W-1:0] smp, logic on,
                                    logic [RELOAD_W-1:0] reload);
        dir_row_t r;
        r.kind = ROW_CHECK;
        r.word = '{op: op, skip_len: 1'b1, clk_env: 1'b1, len: len};
        r.out = '{sample: smp, on: on, reload: reload};
        r.reg_idx = '0;
        r.reg_val = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        dir_row_t r;
        r.kind = ROW_CFG;
        r.word = '0;
        r.out = '0;
        r.reg_idx = idx;
        r.reg_val = val;
        dir_rows.push_back(r);
    endfunction

    // receiver: random stalls, plus a long hold-off whenever one is requested
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall = 1'b1;
            hold_left = hold_left - 1;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served = holds_served + 1;
            hold_left = HOLD_CYCLES - 1;
            out_stall = 1'b1;
        end
        else
        begin
            out_stall = ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        chan_out_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (expected_out_q.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected result word: sample=%0d on=%0b reload=%0d",
                             sample, channel_on, timer_reload);
            end
            else
            begin
                exp_w = expected_out_q.pop_front();
                if (sample !== exp_w.sample || channel_on !== exp_w.on ||
                    timer_reload !== exp_w.reload)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("word %0d: exp %0d/%0b/%0d got %0d/%0b/%0d",
                                 n_results, exp_w.sample, exp_w.on, exp_w.reload,
                                 sample, channel_on, timer_reload);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (in_valid && in_stall)
            backpressure_cycles <= backpressure_cycles + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_out_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int unsigned phase_send [3];
        int unsigned phase_stall [3];
        phase_send  = '{29, 82, 0};
        phase_stall = '{82, 29, 0};

        lfsr_q = '0;
        ch_enabled = 1'b0;
        len_left = '0;
        vol_q = '0;
        env_tmr = '0;
        env_stop = 1'b0;
        r_start_vol = '0;
        r_env_inc = 1'b0;
        r_env_period = '0;
        r_div_code = '0;
        r_clk_shift = '0;
        r_short = 1'b0;
        r_len_on = 1'b0;

        // after reset: LFSR is zero but the channel is off, so nothing sounds
        row_chk(CMD_LFSR_STEP, '0, '0, 1'b0, '0);
        row_chk(CMD_UNUSED, '0, '0, 1'b0, '0);
        row_chk(CMD_LEN_LOAD, '1, '0, 1'b0, '0);
        // start volume 0 with decreasing envelope: DAC off, smallest reload
        row_chk(CMD_TRIGGER, '0, '0, 1'b0, 22'd8);
        row_cfg(REG_START_VOLUME, 4'd15);
        row_cfg(REG_ENV_INCREASE, 4'd1);
        row_cfg(REG_ENV_PERIOD, 4'd7);
        row_cfg(REG_DIVISOR_CODE, 4'd7);
        row_cfg(REG_CLOCK_SHIFT, 4'd15);
        row_cfg(REG_SHORT_MODE, 4'd1);
        row_cfg(REG_LENGTH_ON, 4'd1);
        row_cmd(CMD_LEN_LOAD, 1'b0, 1'b0, '0);
        // zero length with skip reloads 63; LFSR all ones mutes the sample
        row_chk(CMD_TRIGGER, '0, '0, 1'b1, 22'd3670016);
        repeat (4) row_cmd(CMD_LFSR_STEP, 1'b0, 1'b0, '0);
        repeat (3) row_cmd(CMD_ENV_CLK, 1'b0, 1'b0, '0);
        row_cmd(CMD_LEN_CLK, 1'b0, 1'b0, '0);
        row_cmd(CMD_LEN_LOAD, 1'b0, 1'b0, 7'd1);
        row_chk(CMD_LEN_CLK, '0, '0, 1'b0, '0);
        row_cmd(CMD_LEN_LOAD, 1'b0, 1'b0, LENGTH_FULL);
        // period 0 means a frozen envelope with an 8-tick timer
        row_cfg(REG_ENV_PERIOD, 4'd0);
        row_cmd(CMD_TRIGGER, 1'b0, 1'b1, '0);
        row_cmd(CMD_ENV_CLK, 1'b0, 1'b0, '0);
        // decrease from 1 at period 1 runs into the floor and stops
        row_cfg(REG_ENV_PERIOD, 4'd1);
        row_cfg(REG_ENV_INCREASE, 4'd0);
        row_cfg(REG_START_VOLUME, 4'd1);
        row_cmd(CMD_TRIGGER, 1'b0, 1'b0, '0);
        repeat (3) row_cmd(CMD_ENV_CLK, 1'b0, 1'b0, '0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = phase_send[0];
        recv_stall_pct = phase_stall[0];
        foreach (dir_rows[i])
        begin
            case (dir_rows[i].kind)
                ROW_CFG:
                begin
                    settle();
                    cfg_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
                end
                ROW_CHECK: send_cmd(dir_rows[i].word, 1'b1, dir_rows[i].out);
                default:   send_cmd(dir_rows[i].word, 1'b0, '0);
            endcase
        end

        for (int p = 0; p < 3; p++)
        begin
            settle();
            send_idle_pct = phase_send[p];
            recv_stall_pct = phase_stall[p];
            random_config();
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i != 0 && i % RECONFIG_GAP == 0)
                begin
                    settle();
                    random_config();
                end
                // long receiver hold-off while words keep coming
                if (i == 40)
                    hold_requests = hold_requests + 1;
                send_cmd(random_cmd(), 1'b0, '0);
            end
        end

        settle();
        repeat (10) @(posedge clk);

        $display("Ran %0d commands (%0d triggers) over %0d register writes; %0d words checked",
                 n_cmds, n_triggers, n_cfg_writes, n_results);
        $display("Input backpressure seen on %0d cycles, %0d long output hold-offs",
                 backpressure_cycles, holds_served);
        if (err_count == 0 && expected_out_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
